// ===== rtl/hbc_pkg.sv =====
// Package for the linear-bin histogram counter core.
// Holds transaction types, widths, register indexes and the sequencer state type.
// No dependencies; every RTL file of the block refers to it by scoped names.
package hbc_pkg;

  // Storage and count widths.
  localparam int MAX_BUCKETS = 64;
  localparam int ADDR_W      = $clog2(MAX_BUCKETS);
  localparam int NB_W        = $clog2(MAX_BUCKETS + 1);
  localparam int COUNT_W     = 32;

  // Binning arithmetic widths: the offset from range_low and the span
  // both need one bit more than a sample, and the scaled offset adds NB_W.
  localparam int SAMPLE_W    = 16;
  localparam int DIFF_W      = SAMPLE_W + 1;
  localparam int PROD_W      = DIFF_W + NB_W;
  localparam int STEP_W      = $clog2(PROD_W + 1);

  // Configuration register indexes and reset values.
  localparam int CFG_W                        = 2;
  localparam logic [CFG_W-1:0] CFG_RANGE_LOW  = 2'd0;
  localparam logic [CFG_W-1:0] CFG_RANGE_HIGH = 2'd1;
  localparam logic [CFG_W-1:0] CFG_BUCKETS    = 2'd2;
  localparam logic [SAMPLE_W-1:0] RANGE_HIGH_RESET = 16'd200;

  // Input command codes.
  localparam logic CMD_PUSH = 1'b0;
  localparam logic CMD_READ = 1'b1;

  typedef struct packed {
    logic                       cmd;
    logic signed [SAMPLE_W-1:0] sample;
    logic [ADDR_W-1:0]          bucket_index;
  } in_item_t;

  typedef struct packed {
    logic [COUNT_W-1:0] bucket_count;
    logic [COUNT_W-1:0] largest_count;
    logic [COUNT_W-1:0] smallest_count;
    logic               bad_value;
  } out_item_t;

  // Status of the bucket-index divider.
  typedef struct packed {
    logic busy;
    logic done;
  } div_status_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_PREP,
    ST_MUL,
    ST_DIV_GO,
    ST_DIV_WAIT,
    ST_RD,
    ST_UPD,
    ST_SCAN,
    ST_DONE
  } state_t;

endpackage

// ===== rtl/histogram_binning_counter_core.sv =====
// Linear-bin histogram counter core: top level with sequencer and count scan.
// Instantiates hbc_div and hbc_count_ram; depends on hbc_pkg.
//
// One transaction at a time. A push offsets the sample by range_low, scales it
// by the bucket count in one multiply, then runs the divider, which forms the
// quotient one bit at a time, to get the bucket index; the bucket is then
// read, incremented with saturation and written back. Every transaction ends
// with a scan of the buckets in use through the single memory read port, one
// entry per cycle, to find the largest and smallest counts. At most 64 buckets
// are in use. A push below range_low, or any push while range_high is below
// range_low, skips the divider; a push above range_high runs it and is then
// rejected by the index check. The count memory needs no clearing pass after
// reset. A new transaction is accepted while the previous result still waits
// in the output register.
module histogram_binning_counter_core (
  input  logic                           clk,
  input  logic                           rst_n,
  // Input channel
  input  logic                           in_valid,
  output logic                           in_stall,
  input  hbc_pkg::in_item_t              in_data,
  // Result channel
  output logic                           out_valid,
  input  logic                           out_stall,
  output hbc_pkg::out_item_t             out_data,
  // Configuration write port
  input  logic                           cfg_we,
  input  logic [hbc_pkg::CFG_W-1:0]      cfg_index,
  input  logic [hbc_pkg::SAMPLE_W-1:0]   cfg_wdata
);

  // Configuration registers.
  logic [hbc_pkg::SAMPLE_W-1:0] range_low_r;
  logic [hbc_pkg::SAMPLE_W-1:0] range_high_r;
  logic [hbc_pkg::NB_W-1:0]     buckets_r;

  // Sequencer and working registers.
  hbc_pkg::state_t              state_r;
  hbc_pkg::state_t              state_nxt;
  hbc_pkg::in_item_t            item_r;
  logic [hbc_pkg::NB_W-1:0]     n_r;
  logic [hbc_pkg::DIFF_W-1:0]   diff_r;
  logic [hbc_pkg::DIFF_W-1:0]   span_r;
  logic [hbc_pkg::PROD_W-1:0]   prod_r;
  logic [hbc_pkg::ADDR_W-1:0]   addr_r;
  logic                         bad_r;
  logic [hbc_pkg::COUNT_W-1:0]  count_r;
  logic [hbc_pkg::COUNT_W-1:0]  max_r;
  logic [hbc_pkg::COUNT_W-1:0]  min_r;
  logic [hbc_pkg::NB_W-1:0]     scan_idx_r;
  logic                         pend_r;
  logic                         out_valid_r;
  hbc_pkg::out_item_t           out_r;

  // Combinational helpers.
  logic                         in_acc;
  logic                         out_free;
  logic                         push_bad;
  logic [hbc_pkg::NB_W-1:0]     n_act;
  logic [hbc_pkg::DIFF_W-1:0]   sample_ext;
  logic [hbc_pkg::DIFF_W-1:0]   low_ext;
  logic [hbc_pkg::DIFF_W-1:0]   high_ext;
  logic                         scan_issue;
  logic                         idx_bad;

  // Divider and memory connections.
  logic                         div_start;
  logic [hbc_pkg::PROD_W-1:0]   div_quo;
  hbc_pkg::div_status_t         div_st;
  logic                         wr_en;
  logic [hbc_pkg::COUNT_W-1:0]  wr_data;
  logic                         rd_en;
  logic [hbc_pkg::ADDR_W-1:0]   rd_addr;
  logic [hbc_pkg::COUNT_W-1:0]  rd_data;

  hbc_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (prod_r),
    .divisor  (span_r),
    .quotient (div_quo),
    .status   (div_st)
  );

  hbc_count_ram u_ram (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (wr_en),
    .wr_addr (addr_r),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // Configuration writes; indexes past the register list are ignored.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      range_low_r  <= '0;
      range_high_r <= hbc_pkg::RANGE_HIGH_RESET;
      buckets_r    <= hbc_pkg::NB_W'(hbc_pkg::MAX_BUCKETS);
    end else if (cfg_we) begin
      unique case (cfg_index)
        hbc_pkg::CFG_RANGE_LOW:  range_low_r  <= cfg_wdata;
        hbc_pkg::CFG_RANGE_HIGH: range_high_r <= cfg_wdata;
        hbc_pkg::CFG_BUCKETS:    buckets_r    <= cfg_wdata[hbc_pkg::NB_W-1:0];
        default: ;
      endcase
    end
  end

  // Handshake terms.
  assign in_acc   = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;

  // Range checks and sign-extended operands for the binning arithmetic.
  assign n_act = (buckets_r > hbc_pkg::NB_W'(hbc_pkg::MAX_BUCKETS))
               ? hbc_pkg::NB_W'(hbc_pkg::MAX_BUCKETS) : buckets_r;
  assign sample_ext = {item_r.sample[hbc_pkg::SAMPLE_W-1], item_r.sample};
  assign low_ext    = {range_low_r[hbc_pkg::SAMPLE_W-1], range_low_r};
  assign high_ext   = {range_high_r[hbc_pkg::SAMPLE_W-1], range_high_r};
  assign push_bad   = ($signed(item_r.sample) < $signed(range_low_r)) ||
                      ($signed(range_high_r) < $signed(range_low_r));
  assign idx_bad    = (div_quo >= hbc_pkg::PROD_W'(n_r));
  assign scan_issue = (scan_idx_r < n_r);

  // Next-state logic.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      hbc_pkg::ST_IDLE: begin
        if (in_acc) state_nxt = hbc_pkg::ST_PREP;
      end
      hbc_pkg::ST_PREP: begin
        if (item_r.cmd == hbc_pkg::CMD_READ) state_nxt = hbc_pkg::ST_RD;
        else if (push_bad)                   state_nxt = hbc_pkg::ST_SCAN;
        else                                 state_nxt = hbc_pkg::ST_MUL;
      end
      hbc_pkg::ST_MUL:    state_nxt = hbc_pkg::ST_DIV_GO;
      hbc_pkg::ST_DIV_GO: state_nxt = hbc_pkg::ST_DIV_WAIT;
      hbc_pkg::ST_DIV_WAIT: begin
        if (div_st.done) state_nxt = idx_bad ? hbc_pkg::ST_SCAN : hbc_pkg::ST_RD;
      end
      hbc_pkg::ST_RD:  state_nxt = hbc_pkg::ST_UPD;
      hbc_pkg::ST_UPD: state_nxt = hbc_pkg::ST_SCAN;
      hbc_pkg::ST_SCAN: begin
        if (!scan_issue && !pend_r) state_nxt = hbc_pkg::ST_DONE;
      end
      hbc_pkg::ST_DONE: begin
        if (out_free) state_nxt = hbc_pkg::ST_IDLE;
      end
      default: state_nxt = hbc_pkg::ST_IDLE;
    endcase
  end

  // Sequencer outputs: handshake, divider start and memory ports.
  always_comb begin
    in_stall  = (state_r != hbc_pkg::ST_IDLE);
    div_start = (state_r == hbc_pkg::ST_DIV_GO);
    wr_en     = (state_r == hbc_pkg::ST_UPD) && (item_r.cmd == hbc_pkg::CMD_PUSH);
    wr_data   = (rd_data == {hbc_pkg::COUNT_W{1'b1}}) ? rd_data : rd_data + 1'b1;
    rd_en     = 1'b0;
    rd_addr   = addr_r;
    unique case (state_r)
      hbc_pkg::ST_RD: begin
        rd_en = 1'b1;
      end
      hbc_pkg::ST_SCAN: begin
        rd_en   = scan_issue;
        rd_addr = scan_idx_r[hbc_pkg::ADDR_W-1:0];
      end
      default: ;
    endcase
  end

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= hbc_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Working datapath registers.
  always_ff @(posedge clk) begin
    unique case (state_r)
      hbc_pkg::ST_IDLE: begin
        if (in_acc) begin
          item_r <= in_data;
          addr_r <= in_data.bucket_index;
        end
      end
      hbc_pkg::ST_PREP: begin
        n_r     <= n_act;
        diff_r  <= sample_ext - low_ext;
        span_r  <= high_ext - low_ext + 1'b1;
        bad_r   <= (item_r.cmd == hbc_pkg::CMD_PUSH) && push_bad;
        count_r <= '0;
        max_r   <= '0;
        min_r   <= '1;
      end
      hbc_pkg::ST_MUL: begin
        prod_r <= hbc_pkg::PROD_W'(diff_r) * hbc_pkg::PROD_W'(n_r);
      end
      hbc_pkg::ST_DIV_WAIT: begin
        if (div_st.done) begin
          bad_r  <= idx_bad;
          addr_r <= div_quo[hbc_pkg::ADDR_W-1:0];
        end
      end
      hbc_pkg::ST_UPD: begin
        count_r <= (item_r.cmd == hbc_pkg::CMD_PUSH) ? wr_data : rd_data;
      end
      hbc_pkg::ST_SCAN: begin
        if (pend_r) begin
          if (rd_data > max_r) max_r <= rd_data;
          if (rd_data < min_r) min_r <= rd_data;
        end
      end
      default: ;
    endcase
  end

  // Scan control: index of the next read and a flag for data in flight.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scan_idx_r <= '0;
      pend_r     <= 1'b0;
    end else if (state_r == hbc_pkg::ST_SCAN) begin
      pend_r <= scan_issue;
      if (scan_issue) scan_idx_r <= scan_idx_r + 1'b1;
    end else begin
      scan_idx_r <= '0;
      pend_r     <= 1'b0;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if ((state_r == hbc_pkg::ST_DONE) && out_free) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state_r == hbc_pkg::ST_DONE) && out_free) begin
      out_r.bucket_count   <= count_r;
      out_r.largest_count  <= max_r;
      out_r.smallest_count <= min_r;
      out_r.bad_value      <= bad_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // A rejected push never reports a count.
  a_bad_no_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_r.bad_value |-> out_r.bucket_count == '0)
    else $error("bad_value result carries a nonzero bucket_count");

  // Extremes are ordered, or hold the empty-set values when no bucket is in use.
  a_extremes: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_r.largest_count >= out_r.smallest_count) ||
                    (out_r.largest_count == '0 && out_r.smallest_count == '1))
    else $error("largest_count below smallest_count");

  // The divider completes only while the sequencer waits for it.
  a_div_done: assert property (@(posedge clk) disable iff (!rst_n)
    div_st.done |-> state_r == hbc_pkg::ST_DIV_WAIT)
    else $error("divider finished outside its wait state");

  // A counter is written only for an in-range push.
  a_write_ok: assert property (@(posedge clk) disable iff (!rst_n)
    wr_en |-> !bad_r && $past(state_r) == hbc_pkg::ST_RD)
    else $error("bucket write for a rejected or unread transaction");

endmodule

// ===== rtl/hbc_div.sv =====
// Restoring shift-subtract divider, one quotient bit per cycle.
// Used to turn the scaled sample offset into a bucket index.
// Depends on hbc_pkg for widths and the status struct.
module hbc_div (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic [hbc_pkg::PROD_W-1:0]   dividend,
  input  logic [hbc_pkg::DIFF_W-1:0]   divisor,
  output logic [hbc_pkg::PROD_W-1:0]   quotient,
  output hbc_pkg::div_status_t         status
);

  logic [hbc_pkg::DIFF_W-1:0] rem_r;
  logic [hbc_pkg::DIFF_W-1:0] dvs_r;
  logic [hbc_pkg::PROD_W-1:0] quo_r;
  logic [hbc_pkg::STEP_W-1:0] cnt_r;
  logic                       busy_r;
  logic                       done_r;

  logic [hbc_pkg::DIFF_W:0]   trial;
  logic                       fits;

  // One trial subtraction per cycle.
  assign trial = {rem_r, quo_r[hbc_pkg::PROD_W-1]};
  assign fits  = (trial >= {1'b0, dvs_r});

  // Control: step counter and completion pulse.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= hbc_pkg::STEP_W'(hbc_pkg::PROD_W);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == hbc_pkg::STEP_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // Datapath: the dividend shifts out as the quotient shifts in.
  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      dvs_r <= divisor;
      quo_r <= dividend;
    end else if (busy_r) begin
      rem_r <= fits ? hbc_pkg::DIFF_W'(trial - {1'b0, dvs_r})
                    : trial[hbc_pkg::DIFF_W-1:0];
      quo_r <= {quo_r[hbc_pkg::PROD_W-2:0], fits};
    end
  end

  assign quotient    = quo_r;
  assign status.busy = busy_r;
  assign status.done = done_r;

endmodule

// ===== rtl/hbc_count_ram.sv =====
// Bucket counter memory: one write port, one registered read port.
// Per-entry valid bits make every entry read as zero after reset.
// Depends on hbc_pkg for depth and widths.
module hbc_count_ram (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          wr_en,
  input  logic [hbc_pkg::ADDR_W-1:0]    wr_addr,
  input  logic [hbc_pkg::COUNT_W-1:0]   wr_data,
  input  logic                          rd_en,
  input  logic [hbc_pkg::ADDR_W-1:0]    rd_addr,
  output logic [hbc_pkg::COUNT_W-1:0]   rd_data
);

  logic [hbc_pkg::COUNT_W-1:0]     mem [hbc_pkg::MAX_BUCKETS];
  logic [hbc_pkg::MAX_BUCKETS-1:0] vld_r;
  logic [hbc_pkg::COUNT_W-1:0]     rd_data_r;

  // Valid bits are cleared by reset and set by the first write.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (wr_en) begin
      vld_r[wr_addr] <= 1'b1;
    end
  end

  // Storage array write.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read; an entry never written reads as zero.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= vld_r[rd_addr] ? mem[rd_addr] : '0;
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ===== dv/tb_histogram_binning_counter_core.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for histogram_binning_counter_core: directed and random pushes and
// reads under several register settings, checked against a bucket model kept in the bench.
// Depends on hbc_pkg and the core RTL.
module tb_histogram_binning_counter_core;
  import hbc_pkg::*;

  localparam int CYCLE_LIMIT   = 1000000;
  localparam int RANDOM_PHASES = 12;
  localparam int PHASE_ITEMS   = 107;
  localparam int SETTLE_CYCLES = 200;

  logic                clk;
  logic                rst_n     = 1'b0;
  logic                in_valid  = 1'b0;
  logic                in_stall;
  in_item_t            in_data   = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  out_item_t           out_data;
  logic                cfg_we    = 1'b0;
  logic [CFG_W-1:0]    cfg_index = CFG_RANGE_LOW;
  logic [SAMPLE_W-1:0] cfg_wdata = '0;

  // Bucket model state and its copy of the registers.
  logic [COUNT_W-1:0]         bin_count [MAX_BUCKETS];
  logic signed [SAMPLE_W-1:0] low_reg;
  logic signed [SAMPLE_W-1:0] high_reg;
  logic [6:0]                 buckets_reg;
  out_item_t                  pending_results [$];

  int          send_idle_pct = 0;
  int          stall_pct     = 0;
  int          cycle_count   = 0;
  int unsigned n_errors      = 0;
  int unsigned n_sent        = 0;
  int unsigned n_results     = 0;
  int unsigned n_pushes      = 0;
  int unsigned n_reads       = 0;
  int unsigned n_out_of_range = 0;
  int unsigned n_settings    = 0;

  histogram_binning_counter_core i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Hard stop if the run hangs.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles with %0d results pending", cycle_count,
               pending_results.size());
      $display("Simulation FAILED");
      $finish;
    end
  end

  // Random back-pressure on the result channel.
  always @(posedge clk) begin
    out_stall <= ($urandom_range(0, 99) < stall_pct);
  end

  task automatic report_error(input string msg);
    $display("ERROR at %0t ns: %s", $time, msg);
    n_errors++;
  endtask

  // Bins one transaction into the model and returns the result it should produce.
  function automatic out_item_t histogram_step(input in_item_t item);
    out_item_t res;
    longint    val;
    longint    lo;
    longint    hi;
    longint    span;
    longint    slot;
    int        active;
    active = (buckets_reg > MAX_BUCKETS) ? MAX_BUCKETS : int'(buckets_reg);
    res = '0;
    res.smallest_count = '1;
    if (item.cmd == CMD_PUSH) begin
      val = $signed(item.sample);
      lo  = low_reg;
      hi  = high_reg;
      if (val < lo || hi < lo) begin
        res.bad_value = 1'b1;
      end else begin
        span = hi - lo + 1;
        slot = ((val - lo) * active) / span;
        if (slot >= active) begin
          res.bad_value = 1'b1;
        end else begin
          // Counters stick at all ones.
          if (bin_count[int'(slot)] != '1)
            bin_count[int'(slot)] = bin_count[int'(slot)] + 1'b1;
          res.bucket_count = bin_count[int'(slot)];
        end
      end
    end else begin
      res.bucket_count = bin_count[item.bucket_index];
    end
    for (int i = 0; i < active; i++) begin
      if (bin_count[i] > res.largest_count)
        res.largest_count = bin_count[i];
      if (bin_count[i] < res.smallest_count)
        res.smallest_count = bin_count[i];
    end
    return res;
  endfunction

  // Model update on accepted transactions and register writes, plus result checking.
  always @(posedge clk) begin
    out_item_t want;
    out_item_t got;
    if (!rst_n) begin
      foreach (bin_count[i])
        bin_count[i] = '0;
      low_reg     = '0;
      high_reg    = RANGE_HIGH_RESET;
      buckets_reg = 7'd64;
    end else begin
      if (out_valid && !out_stall) begin
        if (pending_results.size() == 0) begin
          report_error("result transaction with none outstanding");
        end else begin
          want = pending_results.pop_front();
          got  = out_data;
          n_results++;
          if (got.bucket_count !== want.bucket_count)
            report_error($sformatf("bucket_count got %h expected %h",
                                   got.bucket_count, want.bucket_count));
          if (got.largest_count !== want.largest_count)
            report_error($sformatf("largest_count got %h expected %h",
                                   got.largest_count, want.largest_count));
          if (got.smallest_count !== want.smallest_count)
            report_error($sformatf("smallest_count got %h expected %h",
                                   got.smallest_count, want.smallest_count));
          if (got.bad_value !== want.bad_value)
            report_error($sformatf("bad_value got %b expected %b",
                                   got.bad_value, want.bad_value));
        end
      end
      if (cfg_we) begin
        case (cfg_index)
          CFG_RANGE_LOW:  low_reg     = cfg_wdata;
          CFG_RANGE_HIGH: high_reg    = cfg_wdata;
          CFG_BUCKETS:    buckets_reg = cfg_wdata[6:0];
          default: ;
        endcase
      end
      if (in_valid && !in_stall) begin
        want = histogram_step(in_data);
        pending_results.push_back(want);
        if (in_data.cmd == CMD_READ) begin
          n_reads++;
        end else begin
          n_pushes++;
          if (want.bad_value)
            n_out_of_range++;
        end
      end
    end
  end

  // Offers one transaction, with an optional random gap first, and waits for acceptance.
  task automatic send_item(input in_item_t item);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    do @(posedge clk); while (in_stall);
    n_sent++;
  endtask

  // Drops valid and waits until every accepted transaction has produced its result.
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (n_results < n_sent)
      @(posedge clk);
  endtask

  // Rewrites all three registers once the core is idle.
  task automatic set_ranges(input int lo, input int hi, input int nb);
    wait_drained();
    cfg_we    <= 1'b1;
    cfg_index <= CFG_RANGE_LOW;
    cfg_wdata <= lo[15:0];
    @(posedge clk);
    cfg_index <= CFG_RANGE_HIGH;
    cfg_wdata <= hi[15:0];
    @(posedge clk);
    cfg_index <= CFG_BUCKETS;
    cfg_wdata <= {9'd0, nb[6:0]};
    @(posedge clk);
    cfg_we <= 1'b0;
    n_settings++;
  endtask

  function automatic in_item_t push_of(input int s);
    in_item_t item;
    logic [31:0] noise;
    noise = $urandom;
    item.cmd          = CMD_PUSH;
    item.sample       = s[15:0];
    item.bucket_index = noise[5:0];
    return item;
  endfunction

  function automatic in_item_t read_of(input int idx);
    in_item_t item;
    logic [31:0] noise;
    noise = $urandom;
    item.cmd          = CMD_READ;
    item.sample       = noise[15:0];
    item.bucket_index = idx[5:0];
    return item;
  endfunction

  // Reset values: range 0..200 over 64 buckets, both ends and just outside them.
  task automatic test_reset_state();
    send_item(read_of(0));
    send_item(read_of(63));
    send_item(push_of(0));
    send_item(push_of(200));
    send_item(push_of(201));
    send_item(push_of(-1));
    send_item(push_of(-32768));
    send_item(push_of(32767));
    send_item(push_of(100));
    send_item(read_of(31));
  endtask

  // Full range, reversed range, no buckets, oversized bucket count and a single bucket.
  task automatic test_register_extremes();
    set_ranges(-32768, 32767, 64);
    send_item(push_of(-32768));
    send_item(push_of(32767));
    send_item(read_of(0));
    set_ranges(32767, -32768, 64);
    send_item(push_of(0));
    send_item(push_of(32767));
    set_ranges(0, 0, 0);
    send_item(push_of(0));
    send_item(read_of(0));
    set_ranges(0, 0, 127);
    send_item(push_of(0));
    send_item(push_of(1));
    set_ranges(-5, 5, 1);
    send_item(push_of(5));
    send_item(push_of(-5));
    send_item(read_of(0));
  endtask

  // One register setting followed by mostly in-range pushes, some reads and some noise.
  task automatic test_random_phase(input int ph);
    int          lo;
    int          hi;
    int          nb;
    int          w;
    int          s;
    int          roll;
    logic [31:0] noise;
    in_item_t    item;
    w  = $urandom_range(0, 400);
    lo = int'($urandom_range(0, 65535)) - 32768;
    hi = (lo + w > 32767) ? 32767 : lo + w;
    nb = $urandom_range(1, 64);
    case (ph % 6)
      1: begin
        lo = -32768;
        hi = 32767;
      end
      2: begin
        hi = int'($urandom_range(0, 65535)) - 32768;
        nb = $urandom_range(0, 127);
      end
      3: nb = 1;
      4: hi = lo;
      5: nb = $urandom_range(65, 127);
      default: ;
    endcase
    set_ranges(lo, hi, nb);
    for (int k = 0; k < PHASE_ITEMS; k++) begin
      roll  = $urandom_range(0, 99);
      noise = $urandom;
      item.cmd          = CMD_PUSH;
      item.sample       = noise[15:0];
      item.bucket_index = noise[21:16];
      if (roll < 15) begin
        item.cmd = CMD_READ;
      end else if (roll < 25) begin
        // Raw sample, anywhere in the 16-bit space.
      end else if (roll < 33) begin
        case ($urandom_range(0, 3))
          0:       s = lo;
          1:       s = hi;
          2:       s = lo - 1;
          default: s = hi + 1;
        endcase
        item.sample = s[15:0];
      end else if (hi >= lo) begin
        s = lo + int'($urandom_range(0, hi - lo));
        item.sample = s[15:0];
      end
      send_item(item);
    end
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_idle_pct = 27;
    stall_pct     = 55;
    test_reset_state();
    test_register_extremes();
    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      if (ph == RANDOM_PHASES / 3) begin
        send_idle_pct = 55;
        stall_pct     = 27;
      end else if (ph == 2 * RANDOM_PHASES / 3) begin
        send_idle_pct = 0;
        stall_pct     = 0;
      end
      test_random_phase(ph);
    end

    // Let stray results show up before closing out.
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (pending_results.size() != 0)
      report_error($sformatf("%0d results never arrived", pending_results.size()));

    $display("Covered %0d transactions: %0d pushes (%0d out of range) and %0d reads,",
             n_sent, n_pushes, n_out_of_range, n_reads);
    $display("over %0d register settings; %0d errors found.", n_settings, n_errors);
    if (n_errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
